// File: rtl/core/ffc_pkg.sv
// ----------------------------------------------------------------------------
// ffc_pkg
// Types and constants shared by the float format converter modules.
// ----------------------------------------------------------------------------
package ffc_pkg;

	typedef enum logic {
		OP_ENCODE,
		OP_DECODE
	} op_t;

	typedef enum logic [1:0] {
		FMT_F32,
		FMT_E5M10,
		FMT_E8M7,
		FMT_E4M3
	} fmt_t;

	typedef struct packed {
		op_t         op;
		fmt_t        fmt;
		logic [31:0] value;
	} req_t;

	localparam int F32_BIAS  = 127;
	localparam int HALF_BIAS = 15;
	localparam int E4M3_BIAS = 7;

	localparam int HALF_SHIFT = F32_BIAS - HALF_BIAS;
	localparam int E4M3_SHIFT = F32_BIAS - E4M3_BIAS;

	localparam logic [31:0] F32_INF  = 32'h7F80_0000;
	localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
	localparam logic [22:0] F32_MANT = 23'h7F_FFFF;

	localparam logic [14:0] HALF_INF  = 15'h7C00;
	localparam logic [14:0] HALF_NAN  = 15'h7E00;
	localparam logic [14:0] BF16_INF  = 15'h7F80;
	localparam logic [14:0] BF16_NAN  = 15'h7FC0;
	localparam logic [6:0]  E4M3_INF  = 7'h78;
	localparam logic [6:0]  E4M3_NAN  = 7'h7F;

endpackage

// File: rtl/core/float_format_converter.sv
// ----------------------------------------------------------------------------
// float_format_converter
// Float32 to and from half, bfloat16 and fp8 e4m3 conversion, one beat a cycle.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one converted beat for each, in order.
// The input beat lands in the s1 register, the format logic between s1 and s2
// converts it, and s2 drives the output. Throughput is one beat every cycle
// while out_stall is low; out_stall propagates to in_stall in the same cycle
// once both registers hold a beat. Encode truncates with no rounding; decoding
// a narrow format turns every NaN into the quiet NaN with the sign kept.
module float_format_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [1:0]  format,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] converted
);
	import ffc_pkg::*;

	logic        valid_s1;
	req_t        req_s1;
	logic        valid_s2;
	logic [31:0] result_s2;
	logic [31:0] result;
	logic        take_s2;
	logic        take_s1;

	assign take_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !take_s2;
	assign take_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1 || take_s2) begin
			valid_s1 <= take_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			req_s1 <= '{op: op_t'(operation), fmt: fmt_t'(format), value: value};
		end
	end

	ffc_datapath u_datapath (
		.req    (req_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign converted = result_s2;

	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("in_stall without a full pipeline");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take_s2 |=> valid_s1 && $stable(req_s1))
		else $error("s1 beat lost while blocked");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		take_s2 && req_s1.fmt == FMT_F32 |=> converted == $past(req_s1.value))
		else $error("identity format altered the value");

	a_e4m3_width: assert property (@(posedge clk) disable iff (!arst_n)
		take_s2 && req_s1.fmt == FMT_E4M3 && req_s1.op == OP_ENCODE
		|=> converted[31:8] == 24'd0)
		else $error("e4m3 code wider than eight bits");

endmodule

// File: rtl/core/ffc_datapath.sv
// ----------------------------------------------------------------------------
// ffc_datapath
// Combinational encode and decode between float32 and the narrow formats.
// ----------------------------------------------------------------------------
module ffc_datapath (
	input  ffc_pkg::req_t req,
	output logic [31:0]   result
);
	import ffc_pkg::*;

	logic        sgn;
	logic [7:0]  exp;
	logic [22:0] man;
	logic [8:0]  half_d;
	logic [8:0]  e4m3_d;
	logic [4:0]  half_e;
	logic [15:0] hc;
	logic [7:0]  qc;
	logic [31:0] enc_half;
	logic [31:0] dec_half;
	logic [31:0] enc_bf16;
	logic [31:0] dec_bf16;
	logic [31:0] enc_e4m3;
	logic [31:0] dec_e4m3;

	assign sgn = req.value[31];
	assign exp = req.value[30:23];
	assign man = req.value[22:0] & F32_MANT;
	assign hc  = req.value[15:0];
	assign qc  = req.value[7:0];

	assign half_d = {1'b0, exp} - 9'(HALF_SHIFT);
	assign e4m3_d = {1'b0, exp} - 9'(E4M3_SHIFT);

	always_comb begin
		if (half_d[8]) begin
			half_e = 5'd0;
		end else if (half_d > 9'd31) begin
			half_e = 5'd31;
		end else begin
			half_e = half_d[4:0];
		end
	end

	always_comb begin
		if (exp == 8'd0) begin
			enc_half = {16'd0, sgn, 5'd0, man[22:13]};
		end else if (exp == 8'hFF) begin
			enc_half = {16'd0, sgn, (man != 23'd0) ? HALF_NAN : HALF_INF};
		end else begin
			enc_half = {16'd0, sgn, half_e, man[22:13]};
		end
	end

	always_comb begin
		if (hc[14:10] == 5'd0) begin
			dec_half = {hc[15], 8'd0, hc[9:0], 13'd0};
		end else if (hc[14:10] == 5'h1F) begin
			dec_half = {hc[15], 31'd0} | ((hc[9:0] != 10'd0) ? F32_QNAN : F32_INF);
		end else begin
			dec_half = {hc[15], 8'(hc[14:10]) + 8'(HALF_SHIFT), hc[9:0], 13'd0};
		end
	end

	always_comb begin
		if (exp == 8'hFF && man != 23'd0) begin
			enc_bf16 = {16'd0, sgn, BF16_NAN};
		end else begin
			enc_bf16 = {16'd0, req.value[31:16]};
		end
	end

	always_comb begin
		if (hc[14:7] == 8'hFF && hc[6:0] != 7'd0) begin
			dec_bf16 = {hc[15], 31'd0} | F32_QNAN;
		end else begin
			dec_bf16 = {hc, 16'd0};
		end
	end

	always_comb begin
		if (exp == 8'd0) begin
			enc_e4m3 = {24'd0, sgn, 4'd0, man[22:20]};
		end else if (exp == 8'hFF) begin
			enc_e4m3 = {24'd0, sgn, (man != 23'd0) ? E4M3_NAN : E4M3_INF};
		end else if (e4m3_d[8]) begin
			enc_e4m3 = {24'd0, sgn, 4'd0, man[22:20]};
		end else if (e4m3_d > 9'd15) begin
			enc_e4m3 = {24'd0, sgn, E4M3_INF};
		end else begin
			enc_e4m3 = {24'd0, sgn, e4m3_d[3:0], man[22:20]};
		end
	end

	always_comb begin
		if (qc[6:3] == 4'd0) begin
			dec_e4m3 = {qc[7], 8'd0, qc[2:0], 20'd0};
		end else if (qc[6:3] == 4'hF) begin
			dec_e4m3 = {qc[7], 31'd0} | ((qc[2:0] != 3'd0) ? F32_QNAN : F32_INF);
		end else begin
			dec_e4m3 = {qc[7], 8'(qc[6:3]) + 8'(E4M3_SHIFT), qc[2:0], 20'd0};
		end
	end

	always_comb begin
		unique case (req.fmt)
			FMT_F32:   result = req.value;
			FMT_E5M10: result = (req.op == OP_DECODE) ? dec_half : enc_half;
			FMT_E8M7:  result = (req.op == OP_DECODE) ? dec_bf16 : enc_bf16;
			FMT_E4M3:  result = (req.op == OP_DECODE) ? dec_e4m3 : enc_e4m3;
		endcase
	end

endmodule

// File: test/float_format_converter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_format_converter_checker
// Watches both channels of the converter, predicts each converted beat and
// compares it with what the block returns.
// ----------------------------------------------------------------------------
// Every accepted input beat is converted here and queued. Every accepted output
// beat is compared against the oldest queued value. Mismatches, output beats
// with nothing queued, and the queue depth are handed to the testbench top.
// ----------------------------------------------------------------------------
module float_format_converter_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        operation,
	input  logic [1:0]  format,
	input  logic [31:0] value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] converted,
	output int          fail_count,
	output int          pending
);
	import ffc_pkg::*;

	typedef struct {
		op_t         op;
		fmt_t        fmt;
		logic [31:0] source;
		logic [31:0] result;
	} conversion_t;

	conversion_t pending_results[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic logic [31:0] convert_value(op_t op, fmt_t fmt, logic [31:0] v);
		logic        s;
		logic [7:0]  e8;
		logic [22:0] m23;
		logic [15:0] c;
		int          r;
		s   = v[31];
		e8  = v[30:23];
		m23 = v[22:0];
		c   = v[15:0];
		convert_value = v;
		case (fmt)
			FMT_E5M10: begin
				if (op == OP_ENCODE) begin
					if (e8 == 8'h00)
						convert_value = {16'h0, s, 5'h0, m23[22:13]};
					else if (e8 == 8'hFF)
						convert_value = {16'h0, s, (m23 != 0) ? HALF_NAN : HALF_INF};
					else begin
						r = int'(e8) - HALF_SHIFT;
						if (r < 0) r = 0;
						if (r > 31) r = 31;
						convert_value = {16'h0, s, 5'(r), m23[22:13]};
					end
				end else begin
					if (c[14:10] == 5'h00)
						convert_value = {c[15], 8'h0, c[9:0], 13'h0};
					else if (c[14:10] == 5'h1F)
						convert_value = {c[15], (c[9:0] != 0) ? F32_QNAN[30:0] : F32_INF[30:0]};
					else
						convert_value = {c[15], 8'(int'(c[14:10]) + HALF_SHIFT), c[9:0], 13'h0};
				end
			end
			FMT_E8M7: begin
				if (op == OP_ENCODE) begin
					if (e8 == 8'hFF && m23 != 0)
						convert_value = {16'h0, s, BF16_NAN};
					else
						convert_value = {16'h0, v[31:16]};
				end else begin
					if (c[14:7] == 8'hFF && c[6:0] != 0)
						convert_value = {c[15], F32_QNAN[30:0]};
					else
						convert_value = {c, 16'h0};
				end
			end
			FMT_E4M3: begin
				if (op == OP_ENCODE) begin
					if (e8 == 8'h00)
						convert_value = {24'h0, s, 4'h0, m23[22:20]};
					else if (e8 == 8'hFF)
						convert_value = {24'h0, s, (m23 != 0) ? E4M3_NAN : E4M3_INF};
					else begin
						r = int'(e8) - E4M3_SHIFT;
						if (r < 0) r = 0;
						if (r > 15)
							convert_value = {24'h0, s, E4M3_INF};
						else
							convert_value = {24'h0, s, 4'(r), m23[22:20]};
					end
				end else begin
					if (v[6:3] == 4'h0)
						convert_value = {v[7], 8'h0, v[2:0], 20'h0};
					else if (v[6:3] == 4'hF)
						convert_value = {v[7], (v[2:0] != 0) ? F32_QNAN[30:0] : F32_INF[30:0]};
					else
						convert_value = {v[7], 8'(int'(v[6:3]) + E4M3_SHIFT), v[2:0], 20'h0};
				end
			end
			default: convert_value = v;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		conversion_t item;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0)
					report_mismatch($sformatf("output beat %h with no beat waiting", converted));
				else begin
					item = pending_results.pop_front();
					if (converted !== item.result)
						report_mismatch($sformatf("%s %s value %h: converted %h, predicted %h",
							item.op.name(), item.fmt.name(), item.source, converted,
							item.result));
				end
			end
			if (in_valid && !in_stall) begin
				item.op     = op_t'(operation);
				item.fmt    = fmt_t'(format);
				item.source = value;
				item.result = convert_value(item.op, item.fmt, value);
				pending_results.push_back(item);
			end
			pending <= pending_results.size();
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the float format converter.
// ----------------------------------------------------------------------------
// Sends a directed set of corner values for every format and direction, then
// random beats biased toward zero, inf, NaN and clamp exponents. The sender
// works in bursts and the receiver stalls on its own pattern, including long
// hold-offs that back the block up. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import ffc_pkg::*;

	localparam int RANDOM_BEATS = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [1:0]  format;
	logic [31:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] converted;
	int          fail_count;
	int          pending;
	int          burst_left;

	float_format_converter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.format    (format),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.converted (converted)
	);

	float_format_converter_checker checker_inst (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.format     (format),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.converted  (converted),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_beat(input op_t op, input fmt_t fmt, input logic [31:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		operation <= op;
		format    <= fmt;
		value     <= v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value(op_t op, fmt_t fmt);
		logic [31:0] v;
		int          kind;
		v    = $urandom;
		kind = $urandom_range(0, 7);
		if (op == OP_ENCODE) begin
			case (kind)
				0: v[30:23] = 8'h00;
				1: v[30:23] = 8'hFF;
				2: begin
					v[30:23] = 8'hFF;
					v[22:0]  = '0;
				end
				3: v[30:23] = 8'($urandom_range(98, 146));
				4: v[30:23] = 8'($urandom_range(110, 138));
				default: ;
			endcase
		end else begin
			case (fmt)
				FMT_E5M10: case (kind)
					0: v[14:10] = 5'h00;
					1: v[14:10] = 5'h1F;
					2: begin
						v[14:10] = 5'h1F;
						v[9:0]   = '0;
					end
					3: v[31:16] = '0;
					default: ;
				endcase
				FMT_E8M7: case (kind)
					0: v[14:7] = 8'h00;
					1: v[14:7] = 8'hFF;
					2: begin
						v[14:7] = 8'hFF;
						v[6:0]  = '0;
					end
					3: v[31:16] = '0;
					default: ;
				endcase
				FMT_E4M3: case (kind)
					0: v[6:3] = 4'h0;
					1: v[6:3] = 4'hF;
					2: begin
						v[6:3] = 4'hF;
						v[2:0] = '0;
					end
					3: v[31:8] = '0;
					default: ;
				endcase
				default: ;
			endcase
		end
		return v;
	endfunction

	// receiver stall pattern with long hold-offs to back up the pipeline
	initial begin
		int mode;
		int len;
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		repeat (150) @(negedge clk);
		hold = 0;
		forever begin
			if (hold == 0 || $urandom_range(0, 15) == 0) begin
				hold++;
				@(negedge clk);
				out_stall <= 1'b1;
				repeat ($urandom_range(60, 120)) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(20, 150);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	initial begin
		op_t  op;
		fmt_t fmt;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		operation  = 1'b0;
		format     = 2'b00;
		value      = '0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corner values for every format and direction
		send_beat(OP_ENCODE, FMT_F32,   32'h0000_0000);
		send_beat(OP_DECODE, FMT_F32,   32'hFFFF_FFFF);
		send_beat(OP_ENCODE, FMT_E5M10, 32'h8000_0000);
		send_beat(OP_ENCODE, FMT_E5M10, 32'h807F_FFFF);
		send_beat(OP_ENCODE, FMT_E5M10, 32'h7F80_0000);
		send_beat(OP_ENCODE, FMT_E5M10, 32'hFFC0_0001);
		send_beat(OP_ENCODE, FMT_E5M10, 32'h3380_0000);
		send_beat(OP_ENCODE, FMT_E5M10, 32'h477F_E000);
		send_beat(OP_ENCODE, FMT_E5M10, 32'h7F7F_FFFF);
		send_beat(OP_ENCODE, FMT_E8M7,  32'hFF80_0001);
		send_beat(OP_ENCODE, FMT_E8M7,  32'hFF80_0000);
		send_beat(OP_DECODE, FMT_E4M3,  32'h0000_0087);
		send_beat(OP_ENCODE, FMT_E4M3,  32'h0070_0000);
		send_beat(OP_ENCODE, FMT_E4M3,  32'h3B00_0000);
		send_beat(OP_ENCODE, FMT_E4M3,  32'h4370_0000);
		send_beat(OP_ENCODE, FMT_E4M3,  32'h43F0_0000);
		send_beat(OP_ENCODE, FMT_E4M3,  32'hC400_0000);
		send_beat(OP_ENCODE, FMT_E4M3,  32'h7FFF_FFFF);
		send_beat(OP_DECODE, FMT_E5M10, 32'hFFFF_7C00);
		send_beat(OP_DECODE, FMT_E5M10, 32'h0000_7E01);
		send_beat(OP_DECODE, FMT_E5M10, 32'h0000_83FF);
		send_beat(OP_DECODE, FMT_E8M7,  32'hABCD_FF81);
		send_beat(OP_DECODE, FMT_E8M7,  32'h0000_7F80);
		send_beat(OP_DECODE, FMT_E4M3,  32'hFFFF_FF7F);
		send_beat(OP_DECODE, FMT_E4M3,  32'h1234_5678);

		repeat (RANDOM_BEATS) begin
			op  = op_t'($urandom_range(0, 1));
			fmt = fmt_t'($urandom_range(0, 3));
			send_beat(op, fmt, pick_value(op, fmt));
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
